### rtl/eqhz_pkg.sv
// Package for the equatorial to horizontal conversion core.
// Holds fixed-point types, angle constants, the CORDIC arctangent table and
// the per-stage step functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eqhz_pkg;

  // Angle resolution of the ports (1/4096 degree) and of the datapath (2^-20)
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int IFRAC           = 20;
  localparam int SCALE_SH        = IFRAC - ANGLE_FRAC_BITS;
  localparam int CORDIC_STAGES_DEF = 20;
  localparam int ATAN_DEPTH      = 32;

  typedef logic signed [33:0] fix_t;    // sines, cosines, ratios: 1.0 = 2^30
  typedef logic signed [31:0] angle_t;  // angles in 2^-20 degree

  localparam fix_t   QONE           = 34'sd1073741824;
  localparam fix_t   CORDIC_GAIN_INV = 34'sd652032874;
  localparam angle_t DEG90          = 32'sd94371840;
  localparam angle_t DEG180         = 32'sd188743680;
  localparam angle_t DEG360         = 32'sd377487360;
  localparam logic [61:0] QONE_SQ   = 62'd1 << 60;
  localparam logic [20:0] AZ_MAX    = 21'(360 << ANGLE_FRAC_BITS);

  // atan(2^-i) in 2^-20 degree
  localparam angle_t ATAN_TAB [ATAN_DEPTH] = '{
    32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
    32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
    32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
    32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
    32'sd917,      32'sd458,      32'sd229,      32'sd115,
    32'sd57,       32'sd29,       32'sd14,       32'sd7,
    32'sd4,        32'sd2,        32'sd1,        32'sd0,
    32'sd0,        32'sd0,        32'sd0,        32'sd0
  };

  // how the acos argument is formed
  typedef enum logic [1:0] {
    RSEL_DIV,
    RSEL_POS,
    RSEL_NEG
  } rsel_t;

  typedef struct packed {
    fix_t   x;
    fix_t   y;
    angle_t z;
  } rot_t;

  typedef struct packed {
    angle_t z;
    logic   neg;
  } fold_t;

  // port angle to datapath angle
  function automatic angle_t to_internal(input angle_t a);
    return a <<< SCALE_SH;
  endfunction

  // reduce to [-180, 180)
  function automatic angle_t wrap180(input angle_t a);
    angle_t r;
    r = a;
    if (r >= DEG180) r = r - DEG360;
    if (r < -DEG180) r = r + DEG360;
    return r;
  endfunction

  // fold into [-90, 90], flag a sign flip of sine and cosine
  function automatic fold_t fold90(input angle_t a);
    fold_t f;
    f.z   = a;
    f.neg = 1'b0;
    if (a > DEG90) begin
      f.z   = a - DEG180;
      f.neg = 1'b1;
    end else if (a < -DEG90) begin
      f.z   = a + DEG180;
      f.neg = 1'b1;
    end
    return f;
  endfunction

  // product of two 30-bit fractions, rounded half up
  function automatic fix_t mulq(input fix_t a, input fix_t b);
    logic signed [67:0] p;
    logic signed [67:0] s;
    p = a * b;
    s = (p + (68'sd1 <<< 29)) >>> 30;
    return s[33:0];
  endfunction

  // one rotation-mode CORDIC step
  function automatic rot_t cordic_rot(input rot_t a, input int i);
    rot_t o;
    fix_t dx;
    fix_t dy;
    dx = a.y >>> i;
    dy = a.x >>> i;
    if (a.z >= 0) begin
      o.x = a.x - dx;
      o.y = a.y + dy;
      o.z = a.z - ATAN_TAB[i];
    end else begin
      o.x = a.x + dx;
      o.y = a.y - dy;
      o.z = a.z + ATAN_TAB[i];
    end
    return o;
  endfunction

  // one vectoring-mode CORDIC step
  function automatic rot_t cordic_vec(input rot_t a, input int i);
    rot_t o;
    fix_t dx;
    fix_t dy;
    dx = a.y >>> i;
    dy = a.x >>> i;
    if (a.y >= 0) begin
      o.x = a.x + dx;
      o.y = a.y - dy;
      o.z = a.z + ATAN_TAB[i];
    end else begin
      o.x = a.x - dx;
      o.y = a.y + dy;
      o.z = a.z - ATAN_TAB[i];
    end
    return o;
  endfunction

  function automatic angle_t clamp90(input angle_t a);
    angle_t r;
    r = a;
    if (r > DEG90) r = DEG90;
    if (r < -DEG90) r = -DEG90;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/equatorial_to_horizontal_core.sv
// Top level of the equatorial to horizontal conversion core.
// Uses eqhz_pkg for types, constants and CORDIC step functions.
`timescale 1ns / 1ps
`default_nettype none

// Converts declination and hour angle (1/4096 degree, signed) into altitude
// and azimuth for the observer latitude written through cfg_we/cfg_wdata.
// The core is a single stall-together pipeline that takes one word per
// cycle while no result waits at the output. It is built from three
// parallel sine/cosine CORDICs, a 31-step square root, the asin CORDIC,
// a 30-step divider, a second square root and the acos CORDIC.
// A result that waits at the output holds the whole pipeline, so in_tready
// follows out_tready whenever a result is pending. out_tuser is set when
// the azimuth denominator vanished (pole or zenith); azimuth is then 0.
module equatorial_to_horizontal_core
  import eqhz_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [19:0] cfg_wdata,    // observer_latitude
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,     // [19:0] declination, [40:20] hour_angle
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,    // [19:0] altitude, [40:20] azimuth
  output logic [0:0]       out_tuser     // [0] degenerate
);

  localparam int N        = CORDIC_STAGES;
  localparam int TS       = (N - 2 > 24) ? 24 : N - 2;
  localparam fix_t EPS    = fix_t'(64'sd1 <<< (30 - TS));
  // pipeline stage map after the sine/cosine section
  localparam int K_MUL2   = 1;
  localparam int K_SALT   = 2;
  localparam int K_SQ1    = 3;
  localparam int K_RAD1   = 4;
  localparam int K_SQRT1  = 5;
  localparam int K_VSET1  = K_SQRT1 + 31;
  localparam int K_VEC1   = K_VSET1 + 1;
  localparam int K_ALT    = K_VEC1 + N;
  localparam int K_DSET   = K_ALT + 1;
  localparam int K_DIV    = K_DSET + 1;
  localparam int K_R      = K_DIV + 30;
  localparam int K_SQ2    = K_R + 1;
  localparam int K_RAD2   = K_SQ2 + 1;
  localparam int K_SQRT2  = K_RAD2 + 1;
  localparam int K_VSET2  = K_SQRT2 + 31;
  localparam int K_VEC2   = K_VSET2 + 1;
  localparam int K_LAST   = K_VEC2 + N - 1;

  typedef struct packed {
    logic  valid;
    rot_t  d;
    rot_t  l;
    rot_t  h;
    logic  neg_d;
    logic  neg_l;
    logic  neg_h;
    logic  hr_pos;
  } sc_t;

  typedef struct packed {
    logic        valid;
    fix_t        sd;
    fix_t        sl;
    fix_t        cl;
    fix_t        ch;
    fix_t        p1;
    fix_t        p2;
    fix_t        salt;
    fix_t        num;
    fix_t        den;
    fix_t        r;
    logic [61:0] rad;
    logic [30:0] root;
    rot_t        v;
    angle_t      alt;
    logic        hr_pos;
    logic        degen;
    logic        rneg;
    rsel_t       rsel;
    logic [33:0] drem;
    logic [33:0] dden;
    logic [29:0] quo;
  } pipe_t;

  logic        en;
  logic [19:0] lat_r;
  sc_t         sc_r [N+1];
  pipe_t       p_r  [K_LAST+1];
  logic        out_valid_r;
  logic [19:0] out_alt_r;
  logic [20:0] out_az_r;
  logic        out_degen_r;

  // whole pipeline moves unless a result is stuck at the output
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // latitude register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= '0;
    end else if (cfg_we) begin
      lat_r <= cfg_wdata;
    end
  end

  // input stage: scale, wrap, fold, seed the three sin/cos CORDICs
  sc_t sc_nxt;
  always_comb begin
    angle_t dec_w;
    angle_t lat_w;
    angle_t ha_w;
    fold_t  fd;
    fold_t  fl;
    fold_t  fh;
    dec_w = wrap180(to_internal(angle_t'($signed(in_tdata[19:0]))));
    ha_w  = wrap180(to_internal(angle_t'($signed(in_tdata[40:20]))));
    lat_w = wrap180(to_internal(angle_t'($signed(lat_r))));
    fd = fold90(dec_w);
    fl = fold90(lat_w);
    fh = fold90(ha_w);
    sc_nxt.valid  = in_tvalid;
    sc_nxt.d      = '{x: CORDIC_GAIN_INV, y: '0, z: fd.z};
    sc_nxt.l      = '{x: CORDIC_GAIN_INV, y: '0, z: fl.z};
    sc_nxt.h      = '{x: CORDIC_GAIN_INV, y: '0, z: fh.z};
    sc_nxt.neg_d  = fd.neg;
    sc_nxt.neg_l  = fl.neg;
    sc_nxt.neg_h  = fh.neg;
    sc_nxt.hr_pos = ha_w > 0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r[0] <= '0;
    end else if (en) begin
      sc_r[0] <= sc_nxt;
    end
  end

  // sin/cos CORDIC stages, one iteration each
  for (genvar i = 1; i <= N; i++) begin : g_sc
    sc_t nxt;
    always_comb begin
      nxt   = sc_r[i-1];
      nxt.d = cordic_rot(sc_r[i-1].d, i - 1);
      nxt.l = cordic_rot(sc_r[i-1].l, i - 1);
      nxt.h = cordic_rot(sc_r[i-1].h, i - 1);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sc_r[i] <= '0;
      end else if (en) begin
        sc_r[i] <= nxt;
      end
    end
  end

  // apply fold signs, first products sin d sin lat and cos d cos lat
  pipe_t p0_nxt;
  always_comb begin
    fix_t cd;
    sc_t  s;
    s  = sc_r[N];
    cd = s.neg_d ? -s.d.x : s.d.x;
    p0_nxt        = '0;
    p0_nxt.valid  = s.valid;
    p0_nxt.sd     = s.neg_d ? -s.d.y : s.d.y;
    p0_nxt.sl     = s.neg_l ? -s.l.y : s.l.y;
    p0_nxt.cl     = s.neg_l ? -s.l.x : s.l.x;
    p0_nxt.ch     = s.neg_h ? -s.h.x : s.h.x;
    p0_nxt.hr_pos = s.hr_pos;
    p0_nxt.p1     = mulq(p0_nxt.sd, p0_nxt.sl);
    p0_nxt.p2     = mulq(cd, p0_nxt.cl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r[0] <= '0;
    end else if (en) begin
      p_r[0] <= p0_nxt;
    end
  end

  // main pipeline: each stage edits its slice of the word record
  for (genvar k = 1; k <= K_LAST; k++) begin : g_p
    pipe_t nxt;
    always_comb begin
      pipe_t       a;
      logic [61:0] t;
      logic [67:0] sq;
      logic [33:0] dt;
      fix_t        num_n;
      fix_t        absn;
      a   = p_r[k-1];
      nxt = a;
      t   = '0;
      sq  = '0;
      dt  = '0;
      num_n = '0;
      absn  = '0;
      if (k == K_MUL2) begin
        nxt.p2 = mulq(a.p2, a.ch);
      end else if (k == K_SALT) begin
        // sin(alt), clamped to [-1, 1]
        nxt.salt = a.p1 + a.p2;
        if (nxt.salt > QONE) nxt.salt = QONE;
        if (nxt.salt < -QONE) nxt.salt = -QONE;
      end else if (k == K_SQ1) begin
        sq      = a.salt * a.salt;
        nxt.rad = sq[61:0];
      end else if (k == K_RAD1 || k == K_RAD2) begin
        nxt.rad  = QONE_SQ - a.rad;
        nxt.root = '0;
      end else if ((k >= K_SQRT1 && k < K_VSET1) || (k >= K_SQRT2 && k < K_VSET2)) begin
        // one root bit per stage, MSB first
        t = ({31'd0, a.root} << (((k >= K_SQRT2) ? (K_VSET2 - k) : (K_VSET1 - k))))
          + (62'd1 << (2 * ((k >= K_SQRT2) ? (K_VSET2 - 1 - k) : (K_VSET1 - 1 - k))));
        if (a.rad >= t) begin
          nxt.rad  = a.rad - t;
          nxt.root = a.root | (31'd1 << ((k >= K_SQRT2) ? (K_VSET2 - 1 - k)
                                                         : (K_VSET1 - 1 - k)));
        end
      end else if (k == K_VSET1) begin
        // cos(alt) = root; start asin, form den and sin lat sin alt
        nxt.v   = '{x: fix_t'({3'd0, a.root}), y: a.salt, z: '0};
        nxt.den = mulq(a.cl, fix_t'({3'd0, a.root}));
        nxt.p1  = mulq(a.sl, a.salt);
      end else if ((k >= K_VEC1 && k < K_ALT) || (k >= K_VEC2)) begin
        nxt.v = cordic_vec(a.v, (k >= K_VEC2) ? (k - K_VEC2) : (k - K_VEC1));
      end else if (k == K_ALT) begin
        // altitude done; numerator, sign-normalized denominator
        nxt.alt = clamp90(a.v.z);
        num_n   = a.sd - a.p1;
        if (a.den < 0) begin
          nxt.den = -a.den;
          nxt.num = -num_n;
        end else begin
          nxt.num = num_n;
        end
      end else if (k == K_DSET) begin
        nxt.degen = a.den < EPS;
        absn      = (a.num < 0) ? -a.num : a.num;
        nxt.rneg  = a.num < 0;
        nxt.drem  = absn;
        nxt.dden  = a.den;
        nxt.quo   = '0;
        if (a.num >= a.den) begin
          nxt.rsel = RSEL_POS;
        end else if (a.num <= -a.den) begin
          nxt.rsel = RSEL_NEG;
        end else begin
          nxt.rsel = RSEL_DIV;
        end
      end else if (k >= K_DIV && k < K_R) begin
        // restoring divide, one quotient bit per stage
        dt = a.drem << 1;
        if (dt >= a.dden) begin
          nxt.drem = dt - a.dden;
          nxt.quo  = {a.quo[28:0], 1'b1};
        end else begin
          nxt.drem = dt;
          nxt.quo  = {a.quo[28:0], 1'b0};
        end
      end else if (k == K_R) begin
        case (a.rsel)
          RSEL_POS: nxt.r = QONE;
          RSEL_NEG: nxt.r = -QONE;
          default:  nxt.r = a.rneg ? -fix_t'({4'd0, a.quo}) : fix_t'({4'd0, a.quo});
        endcase
      end else if (k == K_SQ2) begin
        sq      = a.r * a.r;
        nxt.rad = sq[61:0];
      end else if (k == K_VSET2) begin
        nxt.v = '{x: fix_t'({3'd0, a.root}), y: a.r, z: '0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p_r[k] <= '0;
      end else if (en) begin
        p_r[k] <= nxt;
      end
    end
  end

  // output formatting: azimuth from acos, mirror, round to port units
  logic [19:0] alt_o;
  logic [20:0] az_o;
  always_comb begin
    angle_t az;
    angle_t ar;
    angle_t zr;
    pipe_t  q;
    q  = p_r[K_LAST];
    ar = (q.alt + (32'sd1 <<< (SCALE_SH - 1))) >>> SCALE_SH;
    alt_o = ar[19:0];
    az = DEG90 - clamp90(q.v.z);
    if (q.hr_pos) az = DEG360 - az;
    if (q.degen) az = '0;
    zr = (az + (32'sd1 <<< (SCALE_SH - 1))) >>> SCALE_SH;
    if (zr < 0) begin
      az_o = '0;
    end else if (zr > angle_t'({11'd0, AZ_MAX})) begin
      az_o = AZ_MAX;
    end else begin
      az_o = zr[20:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p_r[K_LAST].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_alt_r   <= alt_o;
      out_az_r    <= az_o;
      out_degen_r <= p_r[K_LAST].degen;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {7'd0, out_az_r, out_alt_r};
  assign out_tuser[0] = out_degen_r;

endmodule

`default_nettype wire

### sim/tb.sv
// Testbench for equatorial_to_horizontal_core: directed and random words,
// checked against an in-bench fixed-point predictor. Depends on rtl/eqhz_pkg.sv.
`timescale 1ns / 1ps

module tb;
  import eqhz_pkg::*;

  localparam int  STAGES     = 20;
  localparam int  LATENCY    = 3 * STAGES + 106;
  localparam int  CYCLE_LIMIT = 600000;
  localparam int  LONG_HOLD  = 500;
  localparam longint ONE_Q   = 64'sd1 << 30;
  localparam longint D90     = 64'sd90 << 20;
  localparam longint D180    = 64'sd180 << 20;
  localparam longint D360    = 64'sd360 << 20;
  localparam longint GAIN_INV = 64'sd652032874;
  localparam longint AZ_TOP  = 64'sd360 << 12;
  localparam int  LAT_MAX    = 368640;
  localparam int  HA_MAX     = 737280;

  localparam longint ARCTAN [32] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic [19:0] alt;
    logic [20:0] az;
    logic        degen;
  } horiz_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [19:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;

  horiz_t      pending_horiz[$];
  logic [19:0] lat_reg = '0;
  int          err_cnt = 0;
  int          result_cnt = 0;
  int          degen_cnt = 0;
  int          word_cnt = 0;
  int          burst_left = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  longint      cycle_cnt = 0;

  equatorial_to_horizontal_core #(.CORDIC_STAGES(STAGES)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results open", cycle_cnt, pending_horiz.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------- predictor ----------------
  function automatic longint wrap_half(input longint a);
    longint r;
    r = a % D360;
    if (r >= D180) r -= D360;
    if (r < -D180) r += D360;
    return r;
  endfunction

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return rnd_shift(a * b, 30);
  endfunction

  function automatic void rot_sincos(input longint ang, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit     flip;
    z = wrap_half(ang); x = GAIN_INV; y = 0; flip = 0;
    if (z > D90) begin z -= D180; flip = 1; end
    else if (z < -D90) begin z += D180; flip = 1; end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin x -= dx; y += dy; z -= ARCTAN[i]; end
      else begin x += dx; y -= dy; z += ARCTAN[i]; end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
      else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // asin by vectoring; also returns sqrt(1 - s^2)
  function automatic longint vec_asin(input longint s_in, output longint root);
    longint s, x, y, z, dx, dy;
    s = s_in;
    if (s > ONE_Q) s = ONE_Q;
    if (s < -ONE_Q) s = -ONE_Q;
    x = int_sqrt((64'd1 << 60) - longint'(s * s));
    root = x; y = s; z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y >= 0) begin x += dx; y -= dy; z += ARCTAN[i]; end
      else begin x -= dx; y += dy; z -= ARCTAN[i]; end
    end
    if (z > D90) z = D90;
    if (z < -D90) z = -D90;
    return z;
  endfunction

  function automatic horiz_t predict_horizontal(input logic [19:0] dec_w,
                                                input logic [20:0] ha_w,
                                                input logic [19:0] lat_w);
    longint dec, ha, lat, sd, cd, sl, cl, sh, ch, salt, calt, alt, num, den, az, r, dmy;
    horiz_t o;
    dec = longint'($signed(dec_w)) * 256;
    ha  = longint'($signed(ha_w)) * 256;
    lat = longint'($signed(lat_w)) * 256;
    rot_sincos(dec, sd, cd);
    rot_sincos(lat, sl, cl);
    rot_sincos(ha, sh, ch);
    salt = qmul(sd, sl) + qmul(qmul(cd, cl), ch);
    alt = vec_asin(salt, calt);
    if (salt > ONE_Q) salt = ONE_Q;
    if (salt < -ONE_Q) salt = -ONE_Q;
    num = sd - qmul(sl, salt);
    den = qmul(cl, calt);
    if (den < 0) begin den = -den; num = -num; end
    az = 0;
    o.degen = 1'b0;
    // pole or zenith: denominator below 2^(30-18)
    if (den < (64'sd1 << 12)) o.degen = 1'b1;
    else begin
      if (num >= den) r = ONE_Q;
      else if (num <= -den) r = -ONE_Q;
      else r = (num * ONE_Q) / den;
      az = D90 - vec_asin(r, dmy);
      if (wrap_half(ha) > 0) az = D360 - az;
    end
    alt = rnd_shift(alt, 8);
    az  = rnd_shift(az, 8);
    if (az < 0) az = 0;
    if (az > AZ_TOP) az = AZ_TOP;
    o.alt = alt[19:0];
    o.az  = az[20:0];
    return o;
  endfunction

  // ---------------- receiver ----------------
  // stall pattern changes every so often; a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(32, 256);
      end else mode_left <= mode_left - 1;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        2: out_tready <= ($urandom_range(0, 9) != 0);
        default: out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk) begin
    horiz_t e;
    if (rst_n && out_tvalid && out_tready) begin
      result_cnt <= result_cnt + 1;
      if (pending_horiz.size() == 0) begin
        err_cnt <= err_cnt + 1;
        if (err_cnt < 10) $display("unexpected result word %h", out_tdata);
      end else begin
        e = pending_horiz.pop_front();
        if (e.degen) degen_cnt <= degen_cnt + 1;
        if (out_tdata[19:0] !== e.alt || out_tdata[40:20] !== e.az ||
            out_tuser[0] !== e.degen || out_tdata[47:41] !== '0) begin
          err_cnt <= err_cnt + 1;
          if (err_cnt < 10)
            $display("mismatch: alt %0d/%0d az %0d/%0d degen %0b/%0b (exp/act)",
                     $signed(e.alt), $signed(out_tdata[19:0]), e.az, out_tdata[40:20],
                     e.degen, out_tuser[0]);
        end
      end
    end
  end

  // ---------------- sender ----------------
  task automatic send_word(input logic [19:0] dec, input logic [20:0] ha);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, ha, dec};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_horiz.push_back(predict_horizontal(dec, ha, lat_reg));
    word_cnt++;
  endtask

  // sender pauses until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_horiz.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_latitude(input logic [19:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    lat_reg = v;
  endtask

  function automatic logic [19:0] rand_dec();
    if ($urandom_range(0, 9) == 0) return 20'($urandom);
    return 20'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
  endfunction

  function automatic logic [20:0] rand_ha();
    if ($urandom_range(0, 9) == 0) return 21'($urandom);
    return 21'($signed($urandom_range(0, 2 * HA_MAX)) - HA_MAX);
  endfunction

  task automatic send_random(input int n);
    for (int k = 0; k < n; k++) send_word(rand_dec(), rand_ha());
  endtask

  // ---------------- tests ----------------
  task automatic test_extremes();
    write_latitude(20'd0);
    send_word(20'(LAT_MAX), 21'd0);
    send_word(20'(-LAT_MAX), 21'd0);
    send_word(20'd0, 21'(HA_MAX));
    send_word(20'd0, 21'(-HA_MAX));
    send_word(20'd0, 21'd1);
    send_word(20'd0, 21'h1FFFFF);
    send_word(20'd0, 21'(HA_MAX / 2));
    send_word(20'h80000, 21'h100000);
    send_word(20'h7FFFF, 21'h0FFFFF);
    send_word(20'd0, 21'd0);          // zenith at the equator
    write_latitude(20'(LAT_MAX));     // north pole observer
    send_word(20'd12345, 21'd4000);
    send_word(20'(LAT_MAX), 21'd0);
    write_latitude(20'(-LAT_MAX));    // south pole observer
    send_word(20'(-LAT_MAX), 21'd0);
    send_word(20'd100, 21'(-200000));
    write_latitude(20'd184320);       // 45 degrees, zenith and nadir cases
    send_word(20'd184320, 21'd0);
    send_word(20'(-184320), 21'(HA_MAX));
    send_word(20'd1000, 21'd1);
    send_word(20'd1000, 21'h1FFFFF);
    write_latitude(20'h80000);        // latitude beyond the pole
    send_word(20'd50000, 21'd300000);
    send_word(20'(-50000), 21'(-300000));
  endtask

  task automatic test_latitudes();
    logic [19:0] lats [5];
    lats = '{20'(LAT_MAX), 20'(-LAT_MAX), 20'd0, 20'h7FFFF, 20'h80000};
    foreach (lats[j]) begin
      write_latitude(lats[j]);
      send_random(40);
    end
    for (int j = 0; j < 6; j++) begin
      write_latitude(20'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX));
      send_random(60);
    end
  endtask

  task automatic test_backpressure();
    write_latitude(20'($urandom));
    hold_req++;
    send_random(120);
  endtask

  task automatic test_pause();
    send_random(20);
    drain();
    send_random(20);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_latitudes();
    test_backpressure();
    test_pause();
    drain();
    $display("sent %0d words over several latitudes, %0d results, %0d degenerate",
             word_cnt, result_cnt, degen_cnt);
    if (err_cnt == 0 && pending_horiz.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("errors: %0d", err_cnt);
      $display("status: fail");
    end
    $finish;
  end

endmodule
